// ===== rtl/mqe_pkg.sv =====
// Shared types, constants and tables for the mouse quadrature emulator.
`timescale 1ns / 1ps
`default_nettype none

package mqe_pkg;

    localparam int MOVE_W       = 16;
    localparam int PERIOD_W     = 14;
    localparam int PHASE_W      = 2;
    localparam int TABLE_SIZE   = 64;
    localparam int TABLE_IDX_W  = 6;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [PERIOD_W-1:0] IDLE_PERIOD = 14'd500;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX  = 14'd12217;

    localparam logic [PERIOD_W-1:0] PERIOD_TABLE [TABLE_SIZE] = '{
        14'd12217, 14'd10241, 14'd8829, 14'd7700, 14'd6758, 14'd5958, 14'd5347, 14'd4782,
        14'd4311,  14'd3888,  14'd3558, 14'd3276, 14'd3041, 14'd2852, 14'd2711, 14'd2570,
        14'd2429,  14'd2335,  14'd2241, 14'd2147, 14'd2052, 14'd1958, 14'd1911, 14'd1817,
        14'd1770,  14'd1723,  14'd1629, 14'd1582, 14'd1535, 14'd1488, 14'd1441, 14'd1394,
        14'd1347,  14'd1300,  14'd1252, 14'd1205, 14'd1158, 14'd1158, 14'd1111, 14'd1064,
        14'd1017,  14'd1017,  14'd970,  14'd923,  14'd923,  14'd876,  14'd876,  14'd829,
        14'd829,   14'd782,   14'd782,  14'd735,  14'd735,  14'd688,  14'd688,  14'd641,
        14'd641,   14'd641,   14'd594,  14'd594,  14'd594,  14'd547,  14'd547,  14'd547
    };

    localparam logic [PHASE_W-1:0] GRAY_CODE [4] = '{2'd0, 2'd1, 2'd3, 2'd2};

    // State of one axis after a transaction, handed from a lane to the merge stage
    typedef struct packed {
        logic [PHASE_W-1:0]         phase;
        logic signed [MOVE_W-1:0]   speed;
        logic [PERIOD_W-1:0]        period;
    } lane_res_t;

endpackage

`default_nettype wire

// ===== rtl/mqe_lane.sv =====
// One axis: sliding window average, period lookup, period counter and phase.
`timescale 1ns / 1ps
`default_nettype none

module mqe_lane #(
    parameter int WINDOW = 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               step_en,
    input  wire logic                               op,
    input  wire logic signed [mqe_pkg::MOVE_W-1:0]  move,
    output mqe_pkg::lane_res_t                      res_next
);

    localparam int SUM_W   = mqe_pkg::MOVE_W + $clog2(WINDOW);
    localparam int SHIFT   = SUM_W + $clog2(WINDOW);
    localparam int PROD_W  = SUM_W + SHIFT + 1;
    localparam longint RECIP_L = ((longint'(1) << SHIFT) + longint'(WINDOW) - 1)
                                 / longint'(WINDOW);
    localparam logic [SHIFT:0] RECIP = (SHIFT+1)'(RECIP_L);

    logic signed [mqe_pkg::MOVE_W-1:0]   win_reg [WINDOW];
    logic signed [SUM_W-1:0]             sum_reg, sum_next;
    logic signed [mqe_pkg::MOVE_W-1:0]   speed_reg, speed_next;
    logic [mqe_pkg::PERIOD_W-1:0]        period_reg, period_next;
    logic [mqe_pkg::PERIOD_W-1:0]        count_reg, count_next;
    logic [mqe_pkg::PHASE_W-1:0]         phase_reg, phase_next;

    logic signed [SUM_W-1:0]             sum_calc;
    logic [SUM_W-1:0]                    sum_u;
    logic [SUM_W-1:0]                    mag;
    logic [PROD_W-1:0]                   prod;
    logic [SUM_W:0]                      quo;
    logic [mqe_pkg::MOVE_W:0]            mag_q;
    logic signed [mqe_pkg::MOVE_W-1:0]   speed_calc;
    logic [mqe_pkg::PERIOD_W-1:0]        period_calc;
    logic [mqe_pkg::PERIOD_W-1:0]        count_inc;
    logic                                wrap;
    logic                                do_sample;
    logic                                do_tick;

    assign do_sample = step_en && (op == mqe_pkg::OP_SAMPLE);
    assign do_tick   = step_en && (op == mqe_pkg::OP_TICK);

    // Oldest sample sits at the far end of the shift line
    assign sum_calc = sum_reg + SUM_W'(move) - SUM_W'(win_reg[WINDOW-1]);
    assign sum_u    = sum_calc;
    assign mag      = sum_calc[SUM_W-1] ? (~sum_u + 1'b1) : sum_u;

    // Truncating divide by WINDOW on the magnitude, via reciprocal multiply
    assign prod  = PROD_W'(mag) * PROD_W'(RECIP);
    assign quo   = prod[PROD_W-1:SHIFT];
    assign mag_q = quo[mqe_pkg::MOVE_W:0];

    assign speed_calc = sum_calc[SUM_W-1] ? mqe_pkg::MOVE_W'(~mag_q + 1'b1)
                                          : mag_q[mqe_pkg::MOVE_W-1:0];

    assign period_calc = (mag_q != '0 && mag_q < (mqe_pkg::MOVE_W+1)'(mqe_pkg::TABLE_SIZE))
                       ? mqe_pkg::PERIOD_TABLE[mag_q[mqe_pkg::TABLE_IDX_W-1:0]]
                       : mqe_pkg::IDLE_PERIOD;

    assign count_inc = count_reg + 1'b1;
    assign wrap      = (count_inc >= period_reg);

    always_comb begin
        sum_next    = sum_reg;
        speed_next  = speed_reg;
        period_next = period_reg;
        count_next  = count_reg;
        phase_next  = phase_reg;
        if (do_sample) begin
            sum_next    = sum_calc;
            speed_next  = speed_calc;
            period_next = period_calc;
        end
        if (do_tick) begin
            count_next = wrap ? '0 : count_inc;
            if (wrap && speed_reg != '0) begin
                // step up for positive speed, down for negative
                phase_next = speed_reg[mqe_pkg::MOVE_W-1] ? phase_reg - 1'b1
                                                          : phase_reg + 1'b1;
            end
        end
    end

    always_comb begin
        res_next.phase  = phase_next;
        res_next.speed  = speed_next;
        res_next.period = period_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW; i++) begin
                win_reg[i] <= '0;
            end
            sum_reg    <= '0;
            speed_reg  <= '0;
            period_reg <= mqe_pkg::IDLE_PERIOD;
            count_reg  <= '0;
            phase_reg  <= '0;
        end else begin
            if (do_sample) begin
                win_reg[0] <= move;
                for (int i = 1; i < WINDOW; i++) begin
                    win_reg[i] <= win_reg[i-1];
                end
            end
            sum_reg    <= sum_next;
            speed_reg  <= speed_next;
            period_reg <= period_next;
            count_reg  <= count_next;
            phase_reg  <= phase_next;
        end
    end

`ifndef ASSERT_OFF
    a_phase_single_step: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (phase_reg == $past(phase_reg)) || (phase_reg == $past(phase_reg) + 2'd1)
                 || (phase_reg == $past(phase_reg) - 2'd1))
        else $error("phase moved by more than one step");

    a_sample_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        do_sample |=> $stable(count_reg) && $stable(phase_reg))
        else $error("sample transaction disturbed the counter or phase");

    a_count_below_period: assert property (@(posedge aclk) disable iff (!aresetn)
        do_tick && wrap |=> count_reg == '0)
        else $error("counter did not return to zero on wrap");
`endif

endmodule

`default_nettype wire

// ===== rtl/mqe_merge.sv =====
// Merge stage: combines both lanes into the output register and gray-codes the phases.
`timescale 1ns / 1ps
`default_nettype none

module mqe_merge (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                accept,
    input  wire mqe_pkg::lane_res_t                  res_x,
    input  wire mqe_pkg::lane_res_t                  res_y,
    output logic                                     take,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_x_phase_a,
    output logic                                     m_x_phase_b,
    output logic                                     m_y_phase_a,
    output logic                                     m_y_phase_b,
    output logic signed [mqe_pkg::MOVE_W-1:0]        m_speed_x_out,
    output logic signed [mqe_pkg::MOVE_W-1:0]        m_speed_y_out,
    output logic [mqe_pkg::PERIOD_W-1:0]             m_period_x_out,
    output logic [mqe_pkg::PERIOD_W-1:0]             m_period_y_out
);

    logic                           valid_reg, valid_next;
    mqe_pkg::lane_res_t             res_x_reg;
    mqe_pkg::lane_res_t             res_y_reg;
    logic [mqe_pkg::PHASE_W-1:0]    gray_x;
    logic [mqe_pkg::PHASE_W-1:0]    gray_y;

    // Accept a new transaction whenever the output slot is empty or draining
    assign take = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_x_reg <= res_x;
            res_y_reg <= res_y;
        end
    end

    assign gray_x = mqe_pkg::GRAY_CODE[res_x_reg.phase];
    assign gray_y = mqe_pkg::GRAY_CODE[res_y_reg.phase];

    assign m_valid        = valid_reg;
    assign m_x_phase_a    = gray_x[0];
    assign m_x_phase_b    = gray_x[1];
    assign m_y_phase_a    = gray_y[0];
    assign m_y_phase_b    = gray_y[1];
    assign m_speed_x_out  = res_x_reg.speed;
    assign m_speed_y_out  = res_y_reg.speed;
    assign m_period_x_out = res_x_reg.period;
    assign m_period_y_out = res_y_reg.period;

endmodule

`default_nettype wire

// ===== rtl/mouse_quadrature_emulator_unit.sv =====
// Top level of the mouse quadrature emulator: two axis lanes and the merge stage.
//
// Usage:
//   Input channel (s_valid/s_ready): s_op selects a movement sample (s_move_x, s_move_y)
//   or a one-microsecond tick. A sample updates each axis window average, speed and
//   step period; a tick advances both period counters and steps the quadrature phases.
//   Result channel (m_valid/m_ready): one transaction per input transaction, carrying
//   the A/B phase bits, speeds and periods as they stand after that input.
//   Result: registered in the merge stage, valid in the cycle after the input is taken.
//   Throughput: one transaction per cycle when not stalled; each lane updates its running sum, divides by
//   WINDOW through a reciprocal multiply and looks up the period combinationally.
//   Stall: while a result waits and m_ready is low, s_ready is low and all state holds;
//   with m_ready high a new input is taken in the same cycle the result leaves.
//   Reset: windows and sums clear to zero, periods load 500, counters and phases clear,
//   no result is pending. No clearing pass is needed; s_ready is high straight after.
`timescale 1ns / 1ps
`default_nettype none

module mouse_quadrature_emulator_unit #(
    parameter int WINDOW = 8
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_op,
    input  wire logic signed [mqe_pkg::MOVE_W-1:0]   s_move_x,
    input  wire logic signed [mqe_pkg::MOVE_W-1:0]   s_move_y,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_x_phase_a,
    output logic                                     m_x_phase_b,
    output logic                                     m_y_phase_a,
    output logic                                     m_y_phase_b,
    output logic signed [mqe_pkg::MOVE_W-1:0]        m_speed_x_out,
    output logic signed [mqe_pkg::MOVE_W-1:0]        m_speed_y_out,
    output logic [mqe_pkg::PERIOD_W-1:0]             m_period_x_out,
    output logic [mqe_pkg::PERIOD_W-1:0]             m_period_y_out
);

    logic               accept;
    logic               take;
    mqe_pkg::lane_res_t res_x;
    mqe_pkg::lane_res_t res_y;

    assign s_ready = take;
    assign accept  = s_valid && take;

    mqe_lane #(.WINDOW(WINDOW)) u_lane_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (accept),
        .op       (s_op),
        .move     (s_move_x),
        .res_next (res_x)
    );

    mqe_lane #(.WINDOW(WINDOW)) u_lane_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (accept),
        .op       (s_op),
        .move     (s_move_y),
        .res_next (res_y)
    );

    mqe_merge u_merge (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .res_x          (res_x),
        .res_y          (res_y),
        .take           (take),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_x_phase_a    (m_x_phase_a),
        .m_x_phase_b    (m_x_phase_b),
        .m_y_phase_a    (m_y_phase_a),
        .m_y_phase_b    (m_y_phase_b),
        .m_speed_x_out  (m_speed_x_out),
        .m_speed_y_out  (m_speed_y_out),
        .m_period_x_out (m_period_x_out),
        .m_period_y_out (m_period_y_out)
    );

`ifndef ASSERT_OFF
    a_result_follows_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted transaction produced no result");

    a_period_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_period_x_out >= mqe_pkg::IDLE_PERIOD)
                 && (m_period_x_out <= mqe_pkg::PERIOD_MAX)
                 && (m_period_y_out >= mqe_pkg::IDLE_PERIOD)
                 && (m_period_y_out <= mqe_pkg::PERIOD_MAX))
        else $error("step period out of table range");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the mouse quadrature emulator: directed table, then random traffic.
`timescale 1ns / 1ps

module testbench;

    localparam int AVG_DEPTH    = 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4;
    localparam int ROW_COUNT    = 22;

    typedef struct packed {
        logic                               x_a;
        logic                               x_b;
        logic                               y_a;
        logic                               y_b;
        logic signed [mqe_pkg::MOVE_W-1:0]  speed_x;
        logic signed [mqe_pkg::MOVE_W-1:0]  speed_y;
        logic [mqe_pkg::PERIOD_W-1:0]       period_x;
        logic [mqe_pkg::PERIOD_W-1:0]       period_y;
    } quad_result_t;

    typedef struct packed {
        logic                               op;
        logic signed [mqe_pkg::MOVE_W-1:0]  mx;
        logic signed [mqe_pkg::MOVE_W-1:0]  my;
        logic                               typed;
        quad_result_t                       want;
    } stim_row_t;

    // Result with both phases still at zero
    function automatic quad_result_t at_rest(input logic signed [mqe_pkg::MOVE_W-1:0] sx,
                                             input logic signed [mqe_pkg::MOVE_W-1:0] sy,
                                             input logic [mqe_pkg::PERIOD_W-1:0] px,
                                             input logic [mqe_pkg::PERIOD_W-1:0] py);
        return '{1'b0, 1'b0, 1'b0, 1'b0, sx, sy, px, py};
    endfunction

    localparam stim_row_t DIRECTED_ROWS [ROW_COUNT] = '{
        // tick straight after reset, move fields ignored
        '{mqe_pkg::OP_TICK,   16'sh7FFF, 16'sh8000, 1'b1,
          at_rest(0, 0, mqe_pkg::IDLE_PERIOD, mqe_pkg::IDLE_PERIOD)},
        '{mqe_pkg::OP_SAMPLE, 16'sd0,    16'sd0,    1'b1,
          at_rest(0, 0, mqe_pkg::IDLE_PERIOD, mqe_pkg::IDLE_PERIOD)},
        // fill the window with the field extremes
        '{mqe_pkg::OP_SAMPLE, 16'sh7FFF, 16'sh8000, 1'b1,
          at_rest(16'sd4095, -16'sd4096, mqe_pkg::IDLE_PERIOD, mqe_pkg::IDLE_PERIOD)},
        '{mqe_pkg::OP_SAMPLE, 16'sh7FFF, 16'sh8000, 1'b0, '0},
        '{mqe_pkg::OP_SAMPLE, 16'sh7FFF, 16'sh8000, 1'b0, '0},
        '{mqe_pkg::OP_SAMPLE, 16'sh7FFF, 16'sh8000, 1'b0, '0},
        '{mqe_pkg::OP_SAMPLE, 16'sh7FFF, 16'sh8000, 1'b0, '0},
        '{mqe_pkg::OP_SAMPLE, 16'sh7FFF, 16'sh8000, 1'b0, '0},
        '{mqe_pkg::OP_SAMPLE, 16'sh7FFF, 16'sh8000, 1'b0, '0},
        '{mqe_pkg::OP_SAMPLE, 16'sh7FFF, 16'sh8000, 1'b1,
          at_rest(16'sh7FFF, 16'sh8000, mqe_pkg::IDLE_PERIOD, mqe_pkg::IDLE_PERIOD)},
        // slowest used and fastest table entries
        '{mqe_pkg::OP_SAMPLE, 16'sd1,    -16'sd63,  1'b0, '0},
        '{mqe_pkg::OP_SAMPLE, 16'sd1,    -16'sd63,  1'b0, '0},
        '{mqe_pkg::OP_SAMPLE, 16'sd1,    -16'sd63,  1'b0, '0},
        '{mqe_pkg::OP_SAMPLE, 16'sd1,    -16'sd63,  1'b0, '0},
        '{mqe_pkg::OP_SAMPLE, 16'sd1,    -16'sd63,  1'b0, '0},
        '{mqe_pkg::OP_SAMPLE, 16'sd1,    -16'sd63,  1'b0, '0},
        '{mqe_pkg::OP_SAMPLE, 16'sd1,    -16'sd63,  1'b0, '0},
        '{mqe_pkg::OP_SAMPLE, 16'sd1,    -16'sd63,  1'b1,
          at_rest(16'sd1, -16'sd63, 14'd10241, 14'd547)},
        // X lands on the table size, Y average -56.25 truncates to -56
        '{mqe_pkg::OP_SAMPLE, 16'sd505,  -16'sd9,   1'b1,
          at_rest(16'sd64, -16'sd56, mqe_pkg::IDLE_PERIOD, 14'd641)},
        '{mqe_pkg::OP_TICK,   16'sh8000, 16'sh7FFF, 1'b0, '0},
        '{mqe_pkg::OP_SAMPLE, 16'sh8000, 16'sh7FFF, 1'b0, '0},
        '{mqe_pkg::OP_TICK,   16'sd0,    16'sd0,    1'b0, '0}
    };

    logic                                 aclk;
    logic                                 aresetn;
    logic                                 s_valid;
    logic                                 s_ready;
    logic                                 s_op;
    logic signed [mqe_pkg::MOVE_W-1:0]    s_move_x;
    logic signed [mqe_pkg::MOVE_W-1:0]    s_move_y;
    logic                                 m_valid;
    logic                                 m_ready;
    logic                                 m_x_phase_a;
    logic                                 m_x_phase_b;
    logic                                 m_y_phase_a;
    logic                                 m_y_phase_b;
    logic signed [mqe_pkg::MOVE_W-1:0]    m_speed_x_out;
    logic signed [mqe_pkg::MOVE_W-1:0]    m_speed_y_out;
    logic [mqe_pkg::PERIOD_W-1:0]         m_period_x_out;
    logic [mqe_pkg::PERIOD_W-1:0]         m_period_y_out;

    // Shadow state of both axes, index 0 is X and 1 is Y
    int                            avg_win [2][AVG_DEPTH] = '{default: 0};
    int                            avg_sum [2]            = '{0, 0};
    int                            axis_speed [2]         = '{0, 0};
    logic [mqe_pkg::PERIOD_W-1:0]  step_period [2]        = '{mqe_pkg::IDLE_PERIOD,
                                                              mqe_pkg::IDLE_PERIOD};
    int                            step_count [2]         = '{0, 0};
    logic [mqe_pkg::PHASE_W-1:0]   quad_phase [2]         = '{2'd0, 2'd0};
    int                            wr_slot                = 0;

    quad_result_t expect_q [$];
    int error_count     = 0;
    int sent_items      = 0;
    int sent_ticks      = 0;
    int checked_results = 0;
    int steps_fwd       = 0;
    int steps_back      = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int item_goal       = 0;

    mouse_quadrature_emulator_unit #(
        .WINDOW(AVG_DEPTH)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_move_x       (s_move_x),
        .s_move_y       (s_move_y),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_x_phase_a    (m_x_phase_a),
        .m_x_phase_b    (m_x_phase_b),
        .m_y_phase_a    (m_y_phase_a),
        .m_y_phase_b    (m_y_phase_b),
        .m_speed_x_out  (m_speed_x_out),
        .m_speed_y_out  (m_speed_y_out),
        .m_period_x_out (m_period_x_out),
        .m_period_y_out (m_period_y_out)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Apply one transaction to the shadow state and return the quadrature outputs after it
    function automatic quad_result_t advance_quadrature(
            input logic op,
            input logic signed [mqe_pkg::MOVE_W-1:0] mx,
            input logic signed [mqe_pkg::MOVE_W-1:0] my);
        quad_result_t                 r;
        int                           mv [2];
        int                           mag;
        logic [mqe_pkg::PHASE_W-1:0]  gray [2];
        mv[0] = mx;
        mv[1] = my;
        for (int a = 0; a < 2; a++) begin
            if (op == mqe_pkg::OP_SAMPLE) begin
                avg_sum[a] += mv[a] - avg_win[a][wr_slot];
                avg_win[a][wr_slot] = mv[a];
                axis_speed[a] = avg_sum[a] / AVG_DEPTH;
                mag = (axis_speed[a] < 0) ? -axis_speed[a] : axis_speed[a];
                step_period[a] = (mag == 0 || mag >= mqe_pkg::TABLE_SIZE)
                               ? mqe_pkg::IDLE_PERIOD : mqe_pkg::PERIOD_TABLE[mag];
            end else begin
                step_count[a] = (step_count[a] + 1) & 32'h3FFF;
                // a period that shrank below the count wraps on the next tick
                if (step_count[a] >= step_period[a]) begin
                    step_count[a] = 0;
                    if (axis_speed[a] > 0) begin
                        quad_phase[a] = quad_phase[a] + 2'd1;
                        steps_fwd++;
                    end else if (axis_speed[a] < 0) begin
                        quad_phase[a] = quad_phase[a] - 2'd1;
                        steps_back++;
                    end
                end
            end
            gray[a] = mqe_pkg::GRAY_CODE[quad_phase[a]];
        end
        if (op == mqe_pkg::OP_SAMPLE)
            wr_slot = (wr_slot == AVG_DEPTH - 1) ? 0 : wr_slot + 1;
        r.x_a      = gray[0][0];
        r.x_b      = gray[0][1];
        r.y_a      = gray[1][0];
        r.y_b      = gray[1][1];
        r.speed_x  = 16'(axis_speed[0]);
        r.speed_y  = 16'(axis_speed[1]);
        r.period_x = step_period[0];
        r.period_y = step_period[1];
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic signed [31:0] want,
                                          input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    task automatic send_item(input logic op, input logic signed [mqe_pkg::MOVE_W-1:0] mx,
                             input logic signed [mqe_pkg::MOVE_W-1:0] my, input logic typed,
                             input quad_result_t typed_want);
        quad_result_t want;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_op     <= op;
        s_move_x <= mx;
        s_move_y <= my;
        do @(posedge aclk); while (!s_ready);
        want = advance_quadrature(op, mx, my);
        expect_q.push_back(typed ? typed_want : want);
        sent_items++;
        if (op == mqe_pkg::OP_TICK)
            sent_ticks++;
    endtask

    // Mostly a run of samples towards a chosen speed then a burst of ticks; some raw noise
    task automatic run_episode();
        int target [2];
        int kind;
        int n_samples;
        int burst;
        int jx;
        int jy;
        kind = $urandom_range(9);
        if (kind < 2) begin
            repeat ($urandom_range(1, 6))
                if (sent_items < item_goal)
                    send_item(1'($urandom_range(1)), 16'($urandom), 16'($urandom), 1'b0, '0);
        end else begin
            for (int a = 0; a < 2; a++) begin
                target[a] = ($urandom_range(9) == 0) ? $urandom_range(4095)
                                                     : $urandom_range(70);
                if ($urandom_range(1) == 1)
                    target[a] = -target[a];
            end
            // a partial window leaves a blend of the old and new speed
            n_samples = (kind < 4) ? $urandom_range(1, AVG_DEPTH - 1) : AVG_DEPTH;
            repeat (n_samples) begin
                jx = $urandom_range(14);
                jy = $urandom_range(14);
                if (sent_items < item_goal)
                    send_item(mqe_pkg::OP_SAMPLE, 16'(target[0] * AVG_DEPTH + jx - 7),
                              16'(target[1] * AVG_DEPTH + jy - 7), 1'b0, '0);
            end
            burst = ($urandom_range(4) == 0) ? $urandom_range(300, 650) : $urandom_range(5, 120);
            repeat (burst)
                if (sent_items < item_goal)
                    send_item(mqe_pkg::OP_TICK, 16'($urandom), 16'($urandom), 1'b0, '0);
        end
    endtask

    initial begin : result_monitor
        quad_result_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (expect_q.size() == 0) begin
                    $error("result transaction arrived with nothing expected");
                    error_count++;
                end else begin
                    want = expect_q.pop_front();
                    checked_results++;
                    compare_field("x_phase_a", want.x_a, m_x_phase_a);
                    compare_field("x_phase_b", want.x_b, m_x_phase_b);
                    compare_field("y_phase_a", want.y_a, m_y_phase_a);
                    compare_field("y_phase_b", want.y_b, m_y_phase_b);
                    compare_field("speed_x_out", want.speed_x, m_speed_x_out);
                    compare_field("speed_y_out", want.speed_y, m_speed_y_out);
                    compare_field("period_x_out", want.period_x, m_period_x_out);
                    compare_field("period_y_out", want.period_y, m_period_y_out);
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("mouse_quadrature_emulator_unit verification failed");
        $finish;
    end

    initial begin : stimulus
        s_valid  <= 1'b0;
        s_op     <= mqe_pkg::OP_SAMPLE;
        s_move_x <= '0;
        s_move_y <= '0;
        m_ready  <= 1'b0;
        aresetn  <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED_ROWS[i])
            send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].mx, DIRECTED_ROWS[i].my,
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

        sender_idle_pct = 36;
        recv_stall_pct  = 78;
        item_goal       = 450;
        while (sent_items < item_goal)
            run_episode();

        // hold off until the result channel has drained completely
        s_valid <= 1'b0;
        do @(posedge aclk); while (expect_q.size() != 0);

        sender_idle_pct = 78;
        recv_stall_pct  = 36;
        item_goal       = 900;
        while (sent_items < item_goal)
            run_episode();

        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        item_goal       = 1350;
        while (sent_items < item_goal)
            run_episode();

        s_valid <= 1'b0;
        do @(posedge aclk); while (expect_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d input transactions (%0d ticks) and %0d checked results,",
                 sent_items, sent_ticks, checked_results);
        $display("with %0d forward and %0d backward quadrature steps over three flow patterns.",
                 steps_fwd, steps_back);
        if (error_count == 0)
            $display("mouse_quadrature_emulator_unit verification clean");
        else
            $display("mouse_quadrature_emulator_unit verification failed");
        $finish;
    end

endmodule
